@@ sv/dcc_frame_bit_serializer_assert.svh @@
// Assertion macros for the DCC frame serializer.
`ifndef DCC_FRAME_BIT_SERIALIZER_ASSERT_SVH
`define DCC_FRAME_BIT_SERIALIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/dcc_fbs_pkg.sv @@
package dcc_fbs_pkg;

   localparam int PREAMBLE_BITS_DEF = 12;
   localparam int FIELD_BITS        = 20;   // everything after the preamble
   localparam int REPEAT_W          = 4;
   localparam logic [REPEAT_W-1:0] REPEAT_RESET = 4'd3;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic load;    // parallel load of the whole frame
      logic shift;   // advance one bit toward cell 0
   } dcc_cell_ctl_type;

   // Bit idx of the frame built from fields = {dir, addr[6:0], speed[7:0]}.
   function automatic logic frame_bit(input int idx, input int preamble,
                                      input logic [15:0] fields);
      int j;
      logic b;
      j = idx - preamble;
      if (idx < preamble)  b = 1'b1;
      else if (j == 0)     b = 1'b0;
      else if (j == 1)     b = fields[15];
      else if (j <= 8)     b = fields[16 - j];
      else if (j == 9)     b = 1'b0;
      else if (j <= 17)    b = fields[17 - j];
      else if (j == 18)    b = 1'b0;
      else                 b = 1'b1;
      return b;
   endfunction

endpackage

@@ sv/dcc_req_if.sv @@
interface dcc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic       direction;
   logic [6:0] dest_addr;
   logic [7:0] speed;

   modport source (output valid, command, direction, dest_addr, speed, input ready);
   modport sink   (input valid, command, direction, dest_addr, speed, output ready);
endinterface

@@ sv/dcc_rsp_if.sv @@
interface dcc_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;

   modport source (output valid, line_level, busy_res, input ready);
   modport sink   (input valid, line_level, busy_res, output ready);
endinterface

@@ sv/dcc_csr_if.sv @@
interface dcc_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ sv/dcc_fbs_cell.sv @@
module dcc_fbs_cell (
   input  logic                          clock,
   input  dcc_fbs_pkg::dcc_cell_ctl_type ctl,
   input  logic                          load_bit,
   input  logic                          shift_in,
   output logic                          bit_out
);
   import dcc_fbs_pkg::*;

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (ctl.load) begin
         bit_in = load_bit;
      end else if (ctl.shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

@@ sv/dcc_frame_bit_serializer.sv @@
// DCC frame bit serializer.
// req_ch: one command per transfer. START latches direction, dest_addr
//   and speed (only when idle; a START while busy replays the held frame
//   from its first bit with the repeat counter cleared). TICK advances the
//   line by one phase while sending; a one bit has two, a zero bit four.
// rsp_ch: exactly one transfer per request, carrying the line level and the
//   busy flag as they stand after that request.
// csr_ch: writes repeat_count (4 bits, 0 behaves as 1); always ready. Write
//   only while idle.
// A response is registered: taken straight into the output register, it is
//   valid the cycle after its request transfer. Throughput: one request per
//   cycle while req_ch is ready. Frame bits sit in cells shifting to
//   cell 0; a tick steps the phase, and a bit's last tick shifts the row.
// Stalls: a two-entry output queue (output register + skid) keeps req_ch
//   ready while one response waits; req_ch ready drops only when both hold.
// Reset: line low, idle, repeat_count = 3, output queue empty. No clearing
//   pass is needed.
module dcc_frame_bit_serializer #(
   parameter int PREAMBLE_BITS = dcc_fbs_pkg::PREAMBLE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dcc_req_if.sink   req_ch,
   dcc_rsp_if.source rsp_ch,
   dcc_csr_if.sink   csr_ch
);
   import dcc_fbs_pkg::*;

   localparam int FRAME_BITS = PREAMBLE_BITS + FIELD_BITS;
   localparam int IDX_W      = $clog2(FRAME_BITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

   // configuration
   logic [REPEAT_W-1:0] repeat_count_ff;

   // sequencer state
   logic [15:0]         fields_ff, fields_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [1:0]          phase_ff, phase_in;
   logic [REPEAT_W-1:0] reps_ff, reps_in;
   logic                sending_ff, sending_in;
   logic                level_ff, level_in;

   // output queue
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_level_ff, rsp_level_in;
   logic rsp_busy_ff, rsp_busy_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_level_ff, skid_level_in;
   logic skid_busy_ff, skid_busy_in;

   dcc_cell_ctl_type        cell_ctl;
   logic [FRAME_BITS-1:0]   cell_q;

   logic                req_fire, rsp_fire;
   logic                cur_bit;
   logic [1:0]          last_phase;
   logic [REPEAT_W:0]   done_cnt;

   // assertion helpers
   logic                idle_tick_fire;
   logic                at_frame_start;

   assign req_ch.ready = !skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;

   assign cur_bit    = cell_q[0];
   assign last_phase = cur_bit ? 2'd1 : 2'd3;
   assign done_cnt   = {1'b0, reps_ff} + (REPEAT_W+1)'(1);

   // next state of the sequencer
   always_comb begin
      fields_in      = fields_ff;
      idx_in         = idx_ff;
      phase_in       = phase_ff;
      reps_in        = reps_ff;
      sending_in     = sending_ff;
      level_in       = level_ff;
      cell_ctl.load  = 1'b0;
      cell_ctl.shift = 1'b0;
      if (req_fire) begin
         if (req_ch.command == CMD_START) begin
            if (!sending_ff) begin
               fields_in  = {req_ch.direction, req_ch.dest_addr, req_ch.speed};
               sending_in = 1'b1;
            end
            idx_in        = '0;
            phase_in      = '0;
            reps_in       = '0;
            cell_ctl.load = 1'b1;
         end else if (sending_ff) begin
            // one bit: high,low; zero bit: high,high,low,low
            level_in = cur_bit ? (phase_ff == 2'd0) : (phase_ff < 2'd2);
            if (phase_ff >= last_phase) begin
               phase_in = '0;
               if (idx_ff == LAST_IDX) begin
                  // frame done: reload the row for the next repeat
                  idx_in        = '0;
                  cell_ctl.load = 1'b1;
                  if (done_cnt >= {1'b0, repeat_count_ff}) begin
                     sending_in = 1'b0;
                     reps_in    = '0;
                  end else begin
                     reps_in = done_cnt[REPEAT_W-1:0];
                  end
               end else begin
                  idx_in         = idx_ff + IDX_W'(1);
                  cell_ctl.shift = 1'b1;
               end
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
      end
   end

   // row of frame-bit cells, cell 0 is the bit on the line
   for (genvar i = 0; i < FRAME_BITS; i++) begin : g_cell
      logic nbr;
      if (i == FRAME_BITS - 1) begin : g_tail
         assign nbr = 1'b1;
      end else begin : g_body
         assign nbr = cell_q[i+1];
      end
      dcc_fbs_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .load_bit (frame_bit(i, PREAMBLE_BITS, fields_in)),
         .shift_in (nbr),
         .bit_out  (cell_q[i])
      );
   end

   // output register plus skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_busy_in   = rsp_busy_ff;
      skid_valid_in = skid_valid_ff;
      skid_level_in = skid_level_ff;
      skid_busy_in  = skid_busy_ff;
      if (!rsp_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_level_in  = skid_level_ff;
            rsp_busy_in   = skid_busy_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = req_fire;
            rsp_level_in = level_in;
            rsp_busy_in  = sending_in;
         end
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_level_in = level_in;
         skid_busy_in  = sending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_count_ff <= REPEAT_RESET;
         fields_ff       <= '0;
         idx_ff          <= '0;
         phase_ff        <= '0;
         reps_ff         <= '0;
         sending_ff      <= 1'b0;
         level_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            repeat_count_ff <= csr_ch.data;
         end
         fields_ff     <= fields_in;
         idx_ff        <= idx_in;
         phase_ff      <= phase_in;
         reps_ff       <= reps_in;
         sending_ff    <= sending_in;
         level_ff      <= level_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload of the output queue
   always_ff @(posedge clock) begin
      rsp_level_ff  <= rsp_level_in;
      rsp_busy_ff   <= rsp_busy_in;
      skid_level_ff <= skid_level_in;
      skid_busy_ff  <= skid_busy_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.line_level = rsp_level_ff;
   assign rsp_ch.busy_res   = rsp_busy_ff;

   assign idle_tick_fire = req_fire && (req_ch.command == CMD_TICK) && !sending_ff;
   assign at_frame_start = (idx_ff == '0) && (phase_ff == 2'd0);

`include "dcc_frame_bit_serializer_assert.svh"

   // skid entry fills only behind a held output entry
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // idle sequencer sits at the frame start
   `ASSERT_IMPLIES(a_idle_counters, clock, reset, !sending_ff, at_frame_start)
   // a one bit never reaches the third half-bit
   `ASSERT_IMPLIES(a_one_bit_phase, clock, reset, sending_ff && cell_q[0], phase_ff <= 2'd1)
   // a tick while idle leaves the line alone
   `ASSERT_NEXT(a_idle_tick_hold, clock, reset, idle_tick_fire, $stable(level_ff) && !sending_ff)

endmodule
